[src/arp_table_with_aging_defines.svh]
// Assertion macros for the ARP table with ageing.
// Depends on nothing; expects signals named clk and rst in the including module.
`ifndef ARP_TABLE_WITH_AGING_DEFINES_SVH
`define ARP_TABLE_WITH_AGING_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define ARP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define ARP_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/arp_pkg.sv]
// Package for the ARP table with ageing: table size, codes and the LFSR step.
// Depends on nothing.
`timescale 1ns / 1ps

package arp_pkg;

  // Table size; the replacement slot takes the low LFSR bits, so keep it a power of two.
  localparam int TABLE_ENTRIES = 32;
  localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
  localparam int IP_W          = 32;
  localparam int MAC_W         = 48;
  localparam int AGE_W         = 8;
  localparam int LFSR_W        = 16;

  localparam logic [AGE_W-1:0]  AGE_MAX         = 8'hFF;
  localparam logic [AGE_W-1:0]  AGE_RESET_LIMIT = 8'd15;
  localparam logic [LFSR_W-1:0] LFSR_SEED       = 16'hACE1;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_TICK   = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_UPDATE = 2'd1,
    KIND_FREE   = 2'd2,
    KIND_RANDOM = 2'd3
  } insert_kind_t;

  // Advance the Fibonacci LFSR one step: taps 16,14,13,11, shift right.
  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
    logic fb;
    fb = v[0] ^ v[2] ^ v[3] ^ v[5];
    return {fb, v[LFSR_W-1:1]};
  endfunction

endpackage

[src/arp_table_with_aging.sv]
// ARP table with ageing: register table, parallel match logic and result register.
// Depends on arp_pkg and arp_table_with_aging_defines.svh.
//
//   channel  | signals                                  | direction
//   ---------+------------------------------------------+----------
//   input    | in_valid, in_stall, opcode, ip_addr,     | in (stall out)
//            | mac_addr                                 |
//   output   | out_valid, out_stall, hit, mac_out,      | out (stall in)
//            | slot_index, insert_kind                  |
//   config   | cfg_wr_en, cfg_wr_data (max_age_ticks)   | in
//
// One beat enters per cycle while in_stall is low; its result passes through the input
// register, then the result register. The 32-entry register table with parallel
// comparators serves one lookup, insert or tick each cycle unless the output stalls.
// Synchronous reset clears valid bits, IPs, ages, sets LFSR to 0xACE1, limit to 15.
// A stall on the output holds the result register; the input register still takes
// one more beat, and in_stall rises only when both registers are full.
`timescale 1ns / 1ps
`include "arp_table_with_aging_defines.svh"

module arp_table_with_aging (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [arp_pkg::AGE_W-1:0]   cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  opcode,
  input  logic [arp_pkg::IP_W-1:0]    ip_addr,
  input  logic [arp_pkg::MAC_W-1:0]   mac_addr,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        hit,
  output logic [arp_pkg::MAC_W-1:0]   mac_out,
  output logic [arp_pkg::SLOT_W-1:0]  slot_index,
  output logic [1:0]                  insert_kind
);
  import arp_pkg::*;

  // Lowest set bit of a table-wide vector.
  function automatic logic [SLOT_W-1:0] first_set(input logic [TABLE_ENTRIES-1:0] v);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (v[i]) idx = SLOT_W'(i);
    end
    return idx;
  endfunction

  // Table state
  logic [TABLE_ENTRIES-1:0] entry_valid;
  logic [IP_W-1:0]          entry_ip  [TABLE_ENTRIES];
  logic [MAC_W-1:0]         entry_mac [TABLE_ENTRIES];
  logic [AGE_W-1:0]         entry_age [TABLE_ENTRIES];
  logic [LFSR_W-1:0]        lfsr;
  logic [AGE_W-1:0]         max_age;

  // Input register
  logic             q_valid;
  logic [1:0]       q_op;
  logic [IP_W-1:0]  q_ip;
  logic [MAC_W-1:0] q_mac;

  // Execute-stage combinational results
  logic                     advance;
  logic                     exec;
  logic [TABLE_ENTRIES-1:0] match_ip;
  logic [TABLE_ENTRIES-1:0] hit_vec;
  logic [TABLE_ENTRIES-1:0] expire_vec;
  logic [AGE_W-1:0]         age_inc [TABLE_ENTRIES];
  logic                     res_hit;
  logic [MAC_W-1:0]         res_mac;
  logic [SLOT_W-1:0]        res_slot;
  logic [1:0]               res_kind;
  logic                     do_write;
  logic                     do_tick;
  logic [LFSR_W-1:0]        lfsr_next;

  // Move the pipeline whenever the result register is free or being drained.
  assign advance  = !out_valid || !out_stall;
  assign exec     = q_valid && advance;
  assign in_stall = q_valid && !advance;

  // Per-entry comparators and age increment, all in parallel.
  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      match_ip[i]   = (entry_ip[i] == q_ip);
      hit_vec[i]    = match_ip[i] && entry_valid[i];
      age_inc[i]    = (entry_age[i] == AGE_MAX) ? entry_age[i] : entry_age[i] + AGE_W'(1);
      expire_vec[i] = (age_inc[i] > max_age);
    end
  end

  // Decide the result and the slot to write.
  always_comb begin
    res_hit   = 1'b0;
    res_mac   = '0;
    res_slot  = '0;
    res_kind  = KIND_NONE;
    do_write  = 1'b0;
    do_tick   = 1'b0;
    lfsr_next = lfsr;
    case (q_op)
      OP_LOOKUP: begin
        if (|hit_vec) begin
          res_hit  = 1'b1;
          res_slot = first_set(hit_vec);
          res_mac  = entry_mac[res_slot];
        end
      end
      OP_INSERT: begin
        do_write = 1'b1;
        if (|match_ip) begin
          // Same IP, valid or not: update in place.
          res_slot = first_set(match_ip);
          res_kind = KIND_UPDATE;
        end else if (!(&entry_valid)) begin
          res_slot = first_set(~entry_valid);
          res_kind = KIND_FREE;
        end else begin
          // Table full: step the LFSR and replace at its low bits.
          lfsr_next = lfsr_step(lfsr);
          res_slot  = lfsr_next[SLOT_W-1:0];
          res_kind  = KIND_RANDOM;
        end
      end
      OP_TICK: begin
        do_tick = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Input register: take a beat unless both stages are held.
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (!in_stall) begin
      q_valid <= in_valid;
    end
    if (in_valid && !in_stall) begin
      q_op  <= opcode;
      q_ip  <= ip_addr;
      q_mac <= mac_addr;
    end
  end

  // Result register: load on advance, hold while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= q_valid;
    end
    if (exec) begin
      hit         <= res_hit;
      mac_out     <= res_mac;
      slot_index  <= res_slot;
      insert_kind <= res_kind;
    end
  end

  // Configuration and control state of the table.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_age     <= AGE_RESET_LIMIT;
      lfsr        <= LFSR_SEED;
      entry_valid <= '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        entry_ip[i]  <= '0;
        entry_age[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        max_age <= cfg_wr_data;
      end
      if (exec) begin
        lfsr <= lfsr_next;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (do_tick) begin
            entry_age[i] <= age_inc[i];
            if (expire_vec[i]) entry_valid[i] <= 1'b0;
          end else if (do_write && res_slot == SLOT_W'(i)) begin
            entry_ip[i]    <= q_ip;
            entry_age[i]   <= '0;
            entry_valid[i] <= 1'b1;
          end
        end
      end
    end
  end

  // MAC store: no reset, read only from entries an insert has made valid.
  always_ff @(posedge clk) begin
    if (exec && do_write) begin
      entry_mac[res_slot] <= q_mac;
    end
  end

  `ARP_ASSERT(a_lfsr_nonzero, lfsr != '0, "replacement LFSR reached zero")
  `ARP_ASSERT(a_random_only_full, (exec && res_kind == KIND_RANDOM) |-> (&entry_valid), "random replace with a free slot")
  `ARP_ASSERT(a_hold_held_beat, (q_valid && !advance) |=> (q_valid && $stable(q_ip) && $stable(q_op)), "held input beat lost")
  `ARP_ASSERT(a_hit_no_kind, (exec && res_hit) |=> (out_valid && hit && insert_kind == KIND_NONE), "lookup hit result malformed")
  `ARP_ASSERT_ALWAYS(a_reset_clears, rst |=> (!q_valid && !out_valid && entry_valid == '0), "reset left state live")

endmodule
